// ----- hdl/cartridge_bank_mapper_scanline_irq_unit_assert.svh -----
// Assertion macros shared by the cartridge mapper RTL.
// Depends on nothing; included by the top level only.
`ifndef CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_UNIT_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cbm_pkg.sv -----
// Shared constants, types and helpers of the cartridge mapper.
// Depends on nothing; used by the channel interfaces and all modules.
package cbm_pkg;

  localparam int PRG_INDEX_BITS_DEF = 9;
  localparam int CHR_INDEX_BITS_DEF = 11;

  // Configuration register widths and the write channel.
  localparam int PCNT_W     = 10;
  localparam int CCNT_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN = 2'd2;

  localparam int PRG_COUNT_RESET = 32;
  localparam int CHR_COUNT_RESET = 256;

  // Operation codes of a command item.
  localparam logic [1:0] OP_MAPPER = 2'd0;
  localparam logic [1:0] OP_OUTER  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Register decode.
  localparam logic [15:0] ADDR_MASK     = 16'hE001;
  localparam logic [15:0] REG_SELECT    = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA = 16'h8001;
  localparam logic [15:0] REG_MIRROR    = 16'hA000;
  localparam logic [15:0] REG_IRQ_OFF   = 16'hC000;
  localparam logic [15:0] REG_IRQ_ON    = 16'hC001;

  localparam logic [7:0] BANK_SEL_MASK = 8'h07;
  localparam logic [7:0] CHR_PAIR_MASK = 8'hFE;
  localparam logic [7:0] PRG_SWAP_BIT  = 8'h40;
  localparam logic [7:0] CHR_SWAP_BIT  = 8'h80;
  localparam logic [7:0] MIRROR_BIT    = 8'h01;
  localparam logic [7:0] IRQ_RELOAD    = 8'hBE;
  localparam logic [8:0] LAST_VISIBLE  = 9'd239;

  // Shared remainder unit: dividend up to 511, divisor up to 4095.
  localparam int DIVD_W = 9;
  localparam int DIVS_W = 12;
  localparam int REM_W  = DIVS_W + 1;
  localparam int STEP_W = $clog2(DIVD_W + 1);

  // Width in which the fixed upper PRG banks are formed.
  localparam int LAST_W = 12;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [REM_W-1:0] remainder;
  } mod_rsp_t;

  // Bank number counted back from the end of PRG ROM; wraps for small counts.
  function automatic logic [LAST_W-1:0] prg_last_f(input logic [PCNT_W-1:0] count,
                                                   input logic back);
    return LAST_W'(count) - LAST_W'(1) - LAST_W'(back);
  endfunction

endpackage

// ----- hdl/cbm_channels.sv -----
// Valid/ready channel interfaces of the cartridge mapper: commands, results
// and configuration writes. Depends on cbm_pkg.

interface cbm_cmd_if import cbm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [15:0] address;
  logic [7:0] data;
  logic [8:0] scanline;
  logic       rendering_on;

  modport source (output valid, output operation, output address, output data,
                  output scanline, output rendering_on, input ready);
  modport sink   (input valid, input operation, input address, input data,
                  input scanline, input rendering_on, output ready);
endinterface

interface cbm_result_if import cbm_pkg::*; #(
  parameter int PRG_INDEX_BITS = PRG_INDEX_BITS_DEF,
  parameter int CHR_INDEX_BITS = CHR_INDEX_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [PRG_INDEX_BITS-1:0]   prg_window_0;
  logic [PRG_INDEX_BITS-1:0]   prg_window_1;
  logic [PRG_INDEX_BITS-1:0]   prg_window_2;
  logic [PRG_INDEX_BITS-1:0]   prg_window_3;
  logic [4*CHR_INDEX_BITS-1:0] chr_windows_low;
  logic [4*CHR_INDEX_BITS-1:0] chr_windows_high;
  logic                        mirroring;
  logic                        irq_pulse;

  modport source (output valid, output prg_window_0, output prg_window_1,
                  output prg_window_2, output prg_window_3, output chr_windows_low,
                  output chr_windows_high, output mirroring, output irq_pulse,
                  input ready);
  modport sink   (input valid, input prg_window_0, input prg_window_1,
                  input prg_window_2, input prg_window_3, input chr_windows_low,
                  input chr_windows_high, input mirroring, input irq_pulse,
                  output ready);
endinterface

interface cbm_cfg_if import cbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/cbm_mod_unit.sv -----
// Shared restoring remainder unit, one dividend bit per cycle.
// Depends on cbm_pkg for widths and the request/response structs.
module cbm_mod_unit import cbm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic              active;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DIVD_W-1:0] dq;
  logic [DIVS_W-1:0] dvs;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_next;

  always_comb begin
    trial = {rem[DIVS_W-1:0], dq[DIVD_W-1]};
    if (trial >= REM_W'(dvs)) begin
      rem_next = trial - REM_W'(dvs);
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else if (req.start) begin
      active <= 1'b1;
      done   <= 1'b0;
    end else if (active) begin
      active <= (step != STEP_W'(1));
      done   <= (step == STEP_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      step <= STEP_W'(DIVD_W);
      dq   <= req.dividend;
      dvs  <= req.divisor;
      rem  <= '0;
    end else if (active) begin
      step <= step - STEP_W'(1);
      dq   <= {dq[DIVD_W-2:0], 1'b0};
      rem  <= rem_next;
    end
  end

  // A zero divisor stands for "no banking" and reduces everything to 0.
  assign rsp.busy      = active;
  assign rsp.done      = done;
  assign rsp.remainder = (dvs == '0) ? '0 : rem;

endmodule

// ----- hdl/cartridge_bank_mapper_scanline_irq_unit.sv -----
// Cartridge bank mapper with MMC3-style registers and a scanline IRQ counter.
// Uses cbm_pkg, the channel interfaces in cbm_channels.sv and cbm_mod_unit.
//
// Usage: every transfer on cmd is a CPU register write, an outer bank write,
// a scanline tick or a no-op, and produces exactly one transfer on result
// carrying the four PRG windows, the eight CHR windows, the mirroring code
// and the IRQ pulse as they stand after that command. The cfg channel writes
// the bank counts and the four-screen flag; it is always ready and is meant
// to be used only while no command is in flight.
// Sequencing: a command that moves no bank number (tick, mirroring or IRQ
// write) goes from S_PICK straight to S_FINISH and the output register. Every
// bank number that must be reduced modulo its bank count goes through the
// single shared remainder unit, which handles one number at a time: a single
// CHR write needs one reduction, a CHR pair, select, PRG or outer write two.
// The first command after a write of the CHR count also re-reduces all eight
// CHR banks.
// Throughput: one command at a time; cmd is ready only while idle.
// Reset (synchronous, rst high) restores every mapper register, maps PRG
// banks 0, 1, 30, 31 and CHR banks 0 to 7, and leaves the unit idle.
// A stalled result waits in the output register; the next command may be
// taken meanwhile but cannot finish until that result has been transferred.

`include "cartridge_bank_mapper_scanline_irq_unit_assert.svh"

module cartridge_bank_mapper_scanline_irq_unit import cbm_pkg::*; #(
  parameter int PRG_INDEX_BITS = PRG_INDEX_BITS_DEF,
  parameter int CHR_INDEX_BITS = CHR_INDEX_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  cbm_cmd_if.sink      cmd,
  cbm_result_if.source result,
  cbm_cfg_if.sink      cfg
);

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PICK   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  // Reduction jobs: the eight CHR bank numbers, then the two PRG numbers.
  typedef enum logic [3:0] {
    JOB_A_LO = 4'd0,
    JOB_A_HI = 4'd1,
    JOB_B_LO = 4'd2,
    JOB_B_HI = 4'd3,
    JOB_S0   = 4'd4,
    JOB_S1   = 4'd5,
    JOB_S2   = 4'd6,
    JOB_S3   = 4'd7,
    JOB_PRG0 = 4'd8,
    JOB_PRG1 = 4'd9
  } job_t;

  localparam int JOB_COUNT  = 10;
  localparam int JOB_W      = 4;
  localparam int CHR_JOBS   = 8;
  localparam int CHR_SLOT_W = 3;

  // Bank select codes (low three bits of the select register).
  localparam logic [2:0] SEL_PAIR_A  = 3'd0;
  localparam logic [2:0] SEL_PAIR_B  = 3'd1;
  localparam logic [2:0] SEL_SINGLE0 = 3'd2;
  localparam logic [2:0] SEL_SINGLE1 = 3'd3;
  localparam logic [2:0] SEL_SINGLE2 = 3'd4;
  localparam logic [2:0] SEL_SINGLE3 = 3'd5;
  localparam logic [2:0] SEL_PRG0    = 3'd6;
  localparam logic [2:0] SEL_PRG1    = 3'd7;

  localparam logic [LAST_W-1:0] RST_LAST1 = LAST_W'(PRG_COUNT_RESET - 2);
  localparam logic [LAST_W-1:0] RST_LAST0 = LAST_W'(PRG_COUNT_RESET - 1);

  // Configuration registers.
  logic [PCNT_W-1:0] prg_count;
  logic [CCNT_W-1:0] chr_count;
  logic              four_screen;

  // Mapper registers.
  logic [7:0] bank_select;
  logic [7:0] chr_pair_a;
  logic [7:0] chr_pair_b;
  logic [7:0] chr_single [4];
  logic [7:0] prg_select [2];
  logic [PRG_INDEX_BITS-1:0] prg_window [4];
  logic       mirror_state;
  logic       irq_enable;
  logic [7:0] irq_counter;
  logic [7:0] irq_reload;

  // Reduced bank numbers and sequencer control.
  logic [CHR_INDEX_BITS-1:0] chr_red [CHR_JOBS];
  logic [PRG_INDEX_BITS-1:0] prg_red [2];
  logic [JOB_COUNT-1:0]      pending;
  logic                      prg_update;
  logic                      prg_outer;
  logic [7:0]                outer_data;
  logic                      pulse_l;
  job_t                      cur_job;
  logic [JOB_W-1:0]          cur_idx;
  state_t                    state;

  // Output register.
  logic                        out_valid;
  logic [PRG_INDEX_BITS-1:0]   out_prg [4];
  logic [4*CHR_INDEX_BITS-1:0] out_chr_lo;
  logic [4*CHR_INDEX_BITS-1:0] out_chr_hi;
  logic                        out_mirror;
  logic                        out_irq;

  // Command decode.
  logic                 cmd_xfer;
  logic                 cfg_xfer;
  logic [15:0]          dec_addr;
  logic [2:0]           sel_code;
  logic                 wr_select;
  logic                 wr_data;
  logic                 wr_mirror;
  logic                 wr_irq_off;
  logic                 wr_irq_on;
  logic                 wr_outer;
  logic                 tick_count;
  logic [JOB_COUNT-1:0] acc_set;
  logic [JOB_COUNT-1:0] cfg_set;
  logic [JOB_COUNT-1:0] clr_mask;

  // Job selection and the shared unit.
  job_t     first_job;
  logic     any_pending;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // Result assembly.
  logic [LAST_W-1:0]         last1_full;
  logic [LAST_W-1:0]         last0_full;
  logic                      prg_swap;
  logic                      chr_swap;
  logic [PRG_INDEX_BITS-1:0] prg_win_new [4];
  logic [4*CHR_INDEX_BITS-1:0] chr_pairs_v;
  logic [4*CHR_INDEX_BITS-1:0] chr_singles_v;
  logic                      out_load;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign dec_addr  = cmd.address & ADDR_MASK;
  assign sel_code  = 3'(bank_select & BANK_SEL_MASK);

  // Decode a command into register updates and the reductions it needs.
  always_comb begin
    wr_select  = 1'b0;
    wr_data    = 1'b0;
    wr_mirror  = 1'b0;
    wr_irq_off = 1'b0;
    wr_irq_on  = 1'b0;
    wr_outer   = 1'b0;
    tick_count = 1'b0;
    acc_set    = '0;
    if (cmd_xfer) begin
      case (cmd.operation)
        OP_MAPPER: begin
          case (dec_addr)
            REG_SELECT: begin
              wr_select         = 1'b1;
              acc_set[JOB_PRG0] = 1'b1;
              acc_set[JOB_PRG1] = 1'b1;
            end
            REG_BANK_DATA: begin
              wr_data = 1'b1;
              case (sel_code)
                SEL_PAIR_A: begin
                  acc_set[JOB_A_LO] = 1'b1;
                  acc_set[JOB_A_HI] = 1'b1;
                end
                SEL_PAIR_B: begin
                  acc_set[JOB_B_LO] = 1'b1;
                  acc_set[JOB_B_HI] = 1'b1;
                end
                SEL_SINGLE0: acc_set[JOB_S0] = 1'b1;
                SEL_SINGLE1: acc_set[JOB_S1] = 1'b1;
                SEL_SINGLE2: acc_set[JOB_S2] = 1'b1;
                SEL_SINGLE3: acc_set[JOB_S3] = 1'b1;
                default: begin
                  // Either PRG select recomputes both switchable windows.
                  acc_set[JOB_PRG0] = 1'b1;
                  acc_set[JOB_PRG1] = 1'b1;
                end
              endcase
            end
            REG_MIRROR:  wr_mirror  = 1'b1;
            REG_IRQ_OFF: wr_irq_off = 1'b1;
            REG_IRQ_ON:  wr_irq_on  = 1'b1;
            default: ;
          endcase
        end
        OP_OUTER: begin
          wr_outer          = 1'b1;
          acc_set[JOB_PRG0] = 1'b1;
          acc_set[JOB_PRG1] = 1'b1;
        end
        OP_TICK: begin
          tick_count = (cmd.scanline <= LAST_VISIBLE) && cmd.rendering_on && irq_enable;
        end
        default: ;
      endcase
    end
  end

  // A new CHR count invalidates every reduced CHR bank.
  always_comb begin
    cfg_set = '0;
    if (cfg_xfer && (cfg.index == CFG_CHR_COUNT)) begin
      cfg_set[CHR_JOBS-1:0] = '1;
    end
  end

  // Lowest pending job goes to the remainder unit first.
  always_comb begin
    first_job = JOB_A_LO;
    for (int i = JOB_COUNT - 1; i >= 0; i--) begin
      if (pending[i]) begin
        first_job = job_t'(JOB_W'(i));
      end
    end
  end

  assign any_pending = |pending;

  always_comb begin
    clr_mask = '0;
    if (mod_req.start) begin
      clr_mask[first_job] = 1'b1;
    end
  end

  // Operands of the chosen job.
  always_comb begin
    mod_req.start = (state == S_PICK) && any_pending;
    case (first_job)
      JOB_A_LO: mod_req.dividend = {1'b0, chr_pair_a};
      JOB_A_HI: mod_req.dividend = {1'b0, chr_pair_a} + DIVD_W'(1);
      JOB_B_LO: mod_req.dividend = {1'b0, chr_pair_b};
      JOB_B_HI: mod_req.dividend = {1'b0, chr_pair_b} + DIVD_W'(1);
      JOB_S0:   mod_req.dividend = {1'b0, chr_single[0]};
      JOB_S1:   mod_req.dividend = {1'b0, chr_single[1]};
      JOB_S2:   mod_req.dividend = {1'b0, chr_single[2]};
      JOB_S3:   mod_req.dividend = {1'b0, chr_single[3]};
      JOB_PRG0: mod_req.dividend = prg_outer ? {outer_data, 1'b0} : {1'b0, prg_select[0]};
      JOB_PRG1: mod_req.dividend = prg_outer ? {outer_data, 1'b1} : {1'b0, prg_select[1]};
      default:  mod_req.dividend = '0;
    endcase
    if ((first_job == JOB_PRG0) || (first_job == JOB_PRG1)) begin
      mod_req.divisor = DIVS_W'(prg_count);
    end else begin
      mod_req.divisor = chr_count;
    end
  end

  cbm_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign cur_idx = cur_job;

  // PRG layout: the swap bit only applies to a recompute, not to an outer write.
  assign last1_full = prg_last_f(prg_count, 1'b1);
  assign last0_full = prg_last_f(prg_count, 1'b0);
  assign prg_swap   = !prg_outer && ((bank_select & PRG_SWAP_BIT) != '0);
  assign chr_swap   = (bank_select & CHR_SWAP_BIT) != '0;

  always_comb begin
    if (prg_update) begin
      if (prg_swap) begin
        prg_win_new[0] = last1_full[PRG_INDEX_BITS-1:0];
        prg_win_new[1] = prg_red[1];
        prg_win_new[2] = prg_red[0];
      end else begin
        prg_win_new[0] = prg_red[0];
        prg_win_new[1] = prg_red[1];
        prg_win_new[2] = last1_full[PRG_INDEX_BITS-1:0];
      end
      prg_win_new[3] = last0_full[PRG_INDEX_BITS-1:0];
    end else begin
      for (int i = 0; i < 4; i++) begin
        prg_win_new[i] = prg_window[i];
      end
    end
  end

  assign chr_pairs_v   = {chr_red[3], chr_red[2], chr_red[1], chr_red[0]};
  assign chr_singles_v = {chr_red[7], chr_red[6], chr_red[5], chr_red[4]};
  assign out_load      = (state == S_FINISH) && (!out_valid || result.ready);

  // Mapper state, reductions and the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count     <= PCNT_W'(PRG_COUNT_RESET);
      chr_count     <= CCNT_W'(CHR_COUNT_RESET);
      four_screen   <= 1'b0;
      bank_select   <= '0;
      chr_pair_a    <= 8'd0;
      chr_pair_b    <= 8'd2;
      chr_single[0] <= 8'd4;
      chr_single[1] <= 8'd5;
      chr_single[2] <= 8'd6;
      chr_single[3] <= 8'd7;
      prg_select[0] <= 8'd0;
      prg_select[1] <= 8'd1;
      prg_window[0] <= PRG_INDEX_BITS'(0);
      prg_window[1] <= PRG_INDEX_BITS'(1);
      prg_window[2] <= RST_LAST1[PRG_INDEX_BITS-1:0];
      prg_window[3] <= RST_LAST0[PRG_INDEX_BITS-1:0];
      mirror_state  <= 1'b0;
      irq_enable    <= 1'b0;
      irq_counter   <= '0;
      irq_reload    <= '0;
      // With the reset CHR count the initial banks are already reduced.
      for (int i = 0; i < CHR_JOBS; i++) begin
        chr_red[i] <= CHR_INDEX_BITS'(i);
      end
      prg_red[0]    <= '0;
      prg_red[1]    <= '0;
      pending       <= '0;
      prg_update    <= 1'b0;
      prg_outer     <= 1'b0;
      pulse_l       <= 1'b0;
      cur_job       <= JOB_A_LO;
      state         <= S_IDLE;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        case (cfg.index)
          CFG_PRG_COUNT:   prg_count   <= cfg.data[PCNT_W-1:0];
          CFG_CHR_COUNT:   chr_count   <= cfg.data[CCNT_W-1:0];
          CFG_FOUR_SCREEN: four_screen <= cfg.data[0];
          default: ;
        endcase
      end

      if (wr_select) begin
        bank_select <= cmd.data;
        prg_update  <= 1'b1;
        prg_outer   <= 1'b0;
      end

      if (wr_data) begin
        case (sel_code)
          SEL_PAIR_A:  chr_pair_a    <= cmd.data & CHR_PAIR_MASK;
          SEL_PAIR_B:  chr_pair_b    <= cmd.data & CHR_PAIR_MASK;
          SEL_SINGLE0: chr_single[0] <= cmd.data;
          SEL_SINGLE1: chr_single[1] <= cmd.data;
          SEL_SINGLE2: chr_single[2] <= cmd.data;
          SEL_SINGLE3: chr_single[3] <= cmd.data;
          SEL_PRG0: begin
            prg_select[0] <= cmd.data;
            prg_update    <= 1'b1;
            prg_outer     <= 1'b0;
          end
          SEL_PRG1: begin
            prg_select[1] <= cmd.data;
            prg_update    <= 1'b1;
            prg_outer     <= 1'b0;
          end
          default: ;
        endcase
      end

      if (wr_mirror && !four_screen) begin
        mirror_state <= (cmd.data & MIRROR_BIT) == '0;
      end

      if (wr_irq_off || wr_irq_on) begin
        irq_enable  <= wr_irq_on;
        irq_reload  <= IRQ_RELOAD;
        irq_counter <= IRQ_RELOAD;
      end

      if (wr_outer) begin
        prg_update <= 1'b1;
        prg_outer  <= 1'b1;
      end

      // The counter reloads and raises the IRQ when it is already at zero.
      if (cmd_xfer) begin
        pulse_l <= tick_count && (irq_counter == '0);
      end
      if (tick_count) begin
        if (irq_counter == '0) begin
          irq_counter <= irq_reload;
        end else begin
          irq_counter <= irq_counter - 8'd1;
        end
      end

      pending <= (pending & ~clr_mask) | acc_set | cfg_set;

      if ((state == S_WAIT) && mod_rsp.done) begin
        if ((cur_job == JOB_PRG0) || (cur_job == JOB_PRG1)) begin
          prg_red[cur_job == JOB_PRG1] <= mod_rsp.remainder[PRG_INDEX_BITS-1:0];
        end else begin
          chr_red[cur_idx[CHR_SLOT_W-1:0]] <= mod_rsp.remainder[CHR_INDEX_BITS-1:0];
        end
      end

      if (out_load) begin
        for (int i = 0; i < 4; i++) begin
          prg_window[i] <= prg_win_new[i];
        end
        prg_update <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (any_pending) begin
            cur_job <= first_job;
            state   <= S_WAIT;
          end else begin
            state <= S_FINISH;
          end
        end
        S_WAIT: begin
          if (mod_rsp.done) begin
            state <= S_PICK;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the outer bank byte and the result fields.
  always_ff @(posedge clk) begin
    if (wr_outer) begin
      outer_data <= cmd.data;
    end
    if (out_load) begin
      for (int i = 0; i < 4; i++) begin
        out_prg[i] <= prg_win_new[i];
      end
      out_chr_lo <= chr_swap ? chr_singles_v : chr_pairs_v;
      out_chr_hi <= chr_swap ? chr_pairs_v : chr_singles_v;
      out_mirror <= mirror_state;
      out_irq    <= pulse_l;
    end
  end

  assign result.valid            = out_valid;
  assign result.prg_window_0     = out_prg[0];
  assign result.prg_window_1     = out_prg[1];
  assign result.prg_window_2     = out_prg[2];
  assign result.prg_window_3     = out_prg[3];
  assign result.chr_windows_low  = out_chr_lo;
  assign result.chr_windows_high = out_chr_hi;
  assign result.mirroring        = out_mirror;
  assign result.irq_pulse        = out_irq;

  // The sequencer starts a reduction only when the shared unit is free.
  `CBM_ASSERT_NOW(a_start_free, clk, rst, mod_req.start, !mod_rsp.busy, "remainder unit restarted while busy")
  // A started reduction keeps the unit busy in the next cycle.
  `CBM_ASSERT_NEXT(a_start_busy, clk, rst, mod_req.start, mod_rsp.busy, "remainder unit did not start")
  // Completion is only reported while the sequencer waits for it.
  `CBM_ASSERT_NOW(a_done_wait, clk, rst, mod_rsp.done, state == S_WAIT, "reduction finished outside wait")
  // While waiting, the unit is either still working or just finished.
  `CBM_ASSERT_NOW(a_wait_live, clk, rst, state == S_WAIT, mod_rsp.busy || mod_rsp.done, "sequencer waits on an idle unit")

endmodule

// ----- tb/cbm_mapper_checker.sv -----
// Scoreboard of the cartridge mapper: follows transfers on the command, result and
// configuration channels and checks each result against a local bank model.
// Depends on cbm_pkg and the channel interfaces in cbm_channels.sv.
module cbm_mapper_checker import cbm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  cbm_cmd_if    cmd,
  cbm_result_if res,
  cbm_cfg_if    cfg,
  output int    outstanding,
  output int    failures
);

  localparam int PB = PRG_INDEX_BITS_DEF;
  localparam int CB = CHR_INDEX_BITS_DEF;

  // Targets of a $8001 write, chosen by bank select bits 2..0.
  localparam logic [2:0] SEL_CHR_PAIR_A = 3'd0;
  localparam logic [2:0] SEL_CHR_PAIR_B = 3'd1;
  localparam logic [2:0] SEL_CHR_1K_0   = 3'd2;
  localparam logic [2:0] SEL_CHR_1K_1   = 3'd3;
  localparam logic [2:0] SEL_CHR_1K_2   = 3'd4;
  localparam logic [2:0] SEL_CHR_1K_3   = 3'd5;
  localparam logic [2:0] SEL_PRG_A      = 3'd6;
  localparam logic [2:0] SEL_PRG_B      = 3'd7;

  typedef struct packed {
    logic [PB-1:0]   prg0;
    logic [PB-1:0]   prg1;
    logic [PB-1:0]   prg2;
    logic [PB-1:0]   prg3;
    logic [4*CB-1:0] chr_lo;
    logic [4*CB-1:0] chr_hi;
    logic            mirror;
    logic            irq;
  } bank_view_t;

  logic [PCNT_W-1:0] prg_count;
  logic [CCNT_W-1:0] chr_count;
  logic              four_scr;

  logic [7:0]    sel_reg;
  logic [7:0]    pair_a;
  logic [7:0]    pair_b;
  logic [7:0]    single_bank [4];
  logic [7:0]    prg_pick [2];
  logic [PB-1:0] prg_win [4];
  logic          mirror_reg;
  logic          irq_on;
  logic [7:0]    irq_cnt;
  logic [7:0]    irq_rld;

  bank_view_t pending_views [$];
  bank_view_t want;
  int         mismatch_cnt = 0;

  function automatic logic [PB-1:0] prg_mod(input int unsigned bank);
    int unsigned r;
    if (prg_count == '0) return '0;
    r = bank % 32'(prg_count);
    return r[PB-1:0];
  endfunction

  // Bank counted back from the end of PRG ROM; wraps for tiny or zero counts.
  function automatic logic [PB-1:0] prg_tail(input int unsigned back);
    int unsigned t;
    t = 32'(prg_count) - 32'd1 - back;
    return t[PB-1:0];
  endfunction

  function automatic logic [CB-1:0] chr_mod(input int unsigned bank);
    int unsigned r;
    if (chr_count == '0) return '0;
    r = bank % 32'(chr_count);
    return r[CB-1:0];
  endfunction

  function automatic logic [4*CB-1:0] pack_chr(input int unsigned s0, input int unsigned s1,
                                               input int unsigned s2, input int unsigned s3);
    return {chr_mod(s3), chr_mod(s2), chr_mod(s1), chr_mod(s0)};
  endfunction

  function automatic void refresh_prg();
    logic [PB-1:0] a;
    logic [PB-1:0] b;
    a = prg_mod(prg_pick[0]);
    b = prg_mod(prg_pick[1]);
    if ((sel_reg & PRG_SWAP_BIT) != '0) begin
      prg_win[0] = prg_tail(1);
      prg_win[1] = b;
      prg_win[2] = a;
    end else begin
      prg_win[0] = a;
      prg_win[1] = b;
      prg_win[2] = prg_tail(1);
    end
    prg_win[3] = prg_tail(0);
  endfunction

  function automatic void init_state();
    prg_count      = PCNT_W'(PRG_COUNT_RESET);
    chr_count      = CCNT_W'(CHR_COUNT_RESET);
    four_scr       = 1'b0;
    sel_reg        = 8'd0;
    pair_a         = 8'd0;
    pair_b         = 8'd2;
    single_bank[0] = 8'd4;
    single_bank[1] = 8'd5;
    single_bank[2] = 8'd6;
    single_bank[3] = 8'd7;
    prg_pick[0]    = 8'd0;
    prg_pick[1]    = 8'd1;
    refresh_prg();
    mirror_reg     = 1'b0;
    irq_on         = 1'b0;
    irq_cnt        = 8'd0;
    irq_rld        = 8'd0;
  endfunction

  function automatic void cpu_write(input logic [15:0] addr, input logic [7:0] data);
    logic [7:0] target;
    target = sel_reg & BANK_SEL_MASK;
    case (addr & ADDR_MASK)
      REG_SELECT: begin
        sel_reg = data;
        refresh_prg();
      end
      REG_BANK_DATA: begin
        case (target[2:0])
          SEL_CHR_PAIR_A: pair_a = data & CHR_PAIR_MASK;
          SEL_CHR_PAIR_B: pair_b = data & CHR_PAIR_MASK;
          SEL_CHR_1K_0:   single_bank[0] = data;
          SEL_CHR_1K_1:   single_bank[1] = data;
          SEL_CHR_1K_2:   single_bank[2] = data;
          SEL_CHR_1K_3:   single_bank[3] = data;
          SEL_PRG_A: begin
            prg_pick[0] = data;
            refresh_prg();
          end
          default: begin
            prg_pick[1] = data;
            refresh_prg();
          end
        endcase
      end
      REG_MIRROR: begin
        if (!four_scr) mirror_reg = ((data & MIRROR_BIT) != '0) ? 1'b0 : 1'b1;
      end
      REG_IRQ_OFF: begin
        irq_on  = 1'b0;
        irq_rld = IRQ_RELOAD;
        irq_cnt = IRQ_RELOAD;
      end
      REG_IRQ_ON: begin
        irq_on  = 1'b1;
        irq_rld = IRQ_RELOAD;
        irq_cnt = IRQ_RELOAD;
      end
      default: ;
    endcase
  endfunction

  // Applies one command and returns the bank view that the mapper must report.
  function automatic bank_view_t map_command(input logic [1:0] op, input logic [15:0] addr,
                                             input logic [7:0] data, input logic [8:0] line,
                                             input logic render);
    bank_view_t  v;
    int unsigned base;
    logic [4*CB-1:0] pairs;
    logic [4*CB-1:0] singles;
    v.irq = 1'b0;
    case (op)
      OP_MAPPER: cpu_write(addr, data);
      OP_OUTER: begin
        base = 32'(data) << 1;
        prg_win[0] = prg_mod(base);
        prg_win[1] = prg_mod(base + 32'd1);
        prg_win[2] = prg_tail(1);
        prg_win[3] = prg_tail(0);
      end
      OP_TICK: begin
        if (line <= LAST_VISIBLE && render && irq_on) begin
          if (irq_cnt == 8'd0) begin
            irq_cnt = irq_rld;
            v.irq   = 1'b1;
          end else begin
            irq_cnt = irq_cnt - 8'd1;
          end
        end
      end
      default: ;
    endcase
    pairs   = pack_chr(pair_a, 32'(pair_a) + 32'd1, pair_b, 32'(pair_b) + 32'd1);
    singles = pack_chr(single_bank[0], single_bank[1], single_bank[2], single_bank[3]);
    if ((sel_reg & CHR_SWAP_BIT) != '0) begin
      v.chr_lo = singles;
      v.chr_hi = pairs;
    end else begin
      v.chr_lo = pairs;
      v.chr_hi = singles;
    end
    v.prg0   = prg_win[0];
    v.prg1   = prg_win[1];
    v.prg2   = prg_win[2];
    v.prg3   = prg_win[3];
    v.mirror = mirror_reg;
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_val,
                                      input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s expected 0x%0h actual 0x%0h", name, exp_val, act_val);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      init_state();
      pending_views.delete();
    end else begin
      // The result is taken first, since it always belongs to an older command.
      if (res.valid && res.ready) begin
        if (pending_views.size() == 0) begin
          $error("result transfer with no command waiting for it");
          mismatch_cnt++;
        end else begin
          want = pending_views.pop_front();
          check_field("prg_window_0", 64'(want.prg0), 64'(res.prg_window_0));
          check_field("prg_window_1", 64'(want.prg1), 64'(res.prg_window_1));
          check_field("prg_window_2", 64'(want.prg2), 64'(res.prg_window_2));
          check_field("prg_window_3", 64'(want.prg3), 64'(res.prg_window_3));
          check_field("chr_windows_low", 64'(want.chr_lo), 64'(res.chr_windows_low));
          check_field("chr_windows_high", 64'(want.chr_hi), 64'(res.chr_windows_high));
          check_field("mirroring", 64'(want.mirror), 64'(res.mirroring));
          check_field("irq_pulse", 64'(want.irq), 64'(res.irq_pulse));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_PRG_COUNT:   prg_count = cfg.data[PCNT_W-1:0];
          CFG_CHR_COUNT:   chr_count = cfg.data[CCNT_W-1:0];
          CFG_FOUR_SCREEN: four_scr  = cfg.data[0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        pending_views.push_back(map_command(cmd.operation, cmd.address, cmd.data,
                                            cmd.scanline, cmd.rendering_on));
      end
    end
    outstanding <= pending_views.size();
    failures    <= mismatch_cnt;
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the cartridge mapper testbench: clock, reset, command and configuration
// stimulus, result back-pressure and the verdict. Depends on cbm_pkg, the channel
// interfaces, the mapper RTL and cbm_mapper_checker.
module testbench;
  import cbm_pkg::*;

  // Operation code that the mapper must ignore.
  localparam logic [1:0] OP_NONE = 2'd3;

  // Generous bound on the run, which sends about 900 commands with gaps and
  // stalls on either side.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Idling control: idle_on switches idling in stretches, calm turns it off for good.
  logic calm;
  logic idle_on;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   sent = 0;

  int outstanding;
  int failures;

  cbm_cmd_if    cmd_ch ();
  cbm_result_if res_ch ();
  cbm_cfg_if    cfg_ch ();

  cartridge_bank_mapper_scanline_irq_unit dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // The checker watches all three channels and keeps its own copy of the mapper.
  cbm_mapper_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .outstanding (outstanding),
    .failures    (failures)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Any result left waiting forever, or a stuck handshake, ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result back-pressure: ready drops in random bursts. A burst is only started
  // while idling is switched on and calm is low, so there are stretches with none.
  always @(posedge clk) begin
    if (rst || calm || !idle_on) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 2);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Presents one command and returns at the edge of its transfer. Valid stays high
  // on return, so a following command goes out back to back unless a gap is drawn.
  task automatic send(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] data,
                      input logic [8:0] line, input logic render);
    if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.operation    <= op;
    cmd_ch.address      <= addr;
    cmd_ch.data         <= data;
    cmd_ch.scanline     <= line;
    cmd_ch.rendering_on <= render;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent++;
  endtask

  // A CPU register write; the tick fields carry noise since the mapper ignores them.
  task automatic cpu_write(input logic [15:0] addr, input logic [7:0] data);
    send(OP_MAPPER, addr, data, 9'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops sending and waits until every result has been transferred. The outstanding
  // count is a registered copy, read after the checker has booked the last transfer.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One random command, or a select write followed by a bank data write. Most of the
  // traffic is scanline ticks on visible, rendered lines, so that the IRQ counter runs
  // down to zero and pulses; the IRQ registers are written rarely, since each write
  // reloads the counter.
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) idle_on <= ~idle_on;
    if (pick < 70) begin
      send(OP_TICK, 16'($urandom), 8'($urandom),
           ($urandom_range(0, 9) != 0) ? 9'($urandom_range(0, 239)) : 9'($urandom_range(240, 511)),
           1'($urandom_range(0, 9) != 0));
    end else if (pick < 80) begin
      cpu_write({3'b100, 12'($urandom), 1'b0}, 8'($urandom));
      cpu_write({3'b100, 12'($urandom), 1'b1}, 8'($urandom));
    end else if (pick < 87) begin
      cpu_write({3'b100, 12'($urandom), 1'b1}, 8'($urandom));
    end else if (pick < 90) begin
      cpu_write({3'b101, 12'($urandom), 1'($urandom)}, 8'($urandom));
    end else if (pick < 91) begin
      if ($urandom_range(0, 1) == 0) begin
        cpu_write({3'b110, 12'($urandom), 1'($urandom_range(0, 3) != 0)}, 8'($urandom));
      end else begin
        send(OP_TICK, 16'($urandom), 8'($urandom), 9'($urandom_range(0, 239)), 1'b1);
      end
    end else if (pick < 95) begin
      send(OP_OUTER, 16'($urandom), 8'($urandom), 9'($urandom), 1'($urandom));
    end else if (pick < 98) begin
      cpu_write(16'($urandom), 8'($urandom));
    end else begin
      send(OP_NONE, 16'($urandom), 8'($urandom), 9'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int k;
    int ph;
    int quota;
    int prg_set [PHASES];
    int chr_set [PHASES];
    int fs_set  [PHASES];

    // Counts for the phases: smallest and largest legal sizes, then the cases outside
    // the legal range (zero PRG banks, a count wider than the bank field), then random.
    prg_set = '{2, 512, 0, 1023, $urandom_range(2, 512), $urandom_range(1, 1023)};
    chr_set = '{0, 2048, 1, 4095, $urandom_range(1, 2048), $urandom_range(0, 4095)};
    fs_set  = '{1, 0, 1, 0, $urandom_range(0, 1), $urandom_range(0, 1)};

    cmd_ch.valid        <= 1'b0;
    cmd_ch.operation    <= OP_MAPPER;
    cmd_ch.address      <= '0;
    cmd_ch.data         <= '0;
    cmd_ch.scanline     <= '0;
    cmd_ch.rendering_on <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_PRG_COUNT;
    cfg_ch.data         <= '0;
    calm                <= 1'b0;
    idle_on             <= 1'b1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, under the reset configuration. A tick before the IRQ is ever
    // enabled must change nothing, and so must the unused operation code.
    send(OP_TICK, 16'h0000, 8'h00, 9'd0, 1'b1);
    send(OP_NONE, 16'hFFFF, 8'hFF, 9'h1FF, 1'b1);

    // Every bank data target once, with both swap bits in all combinations, extreme
    // data bytes, and don't-care address bits both clear and set.
    for (k = 0; k < 8; k++) begin
      cpu_write((k % 2 == 0) ? REG_SELECT : 16'h9FFE,
                8'(k) | ((k % 2 == 1) ? PRG_SWAP_BIT : 8'h00) | ((k / 2 % 2 == 1) ? CHR_SWAP_BIT : 8'h00));
      cpu_write((k % 2 == 0) ? REG_BANK_DATA : 16'h9FFF, (k % 3 == 0) ? 8'h00 : 8'hFF);
    end

    // Mirroring both ways, then the IRQ enabled and ticks at the edges of the
    // visible area, with rendering off, and on the last line of the frame.
    cpu_write(REG_MIRROR, MIRROR_BIT);
    cpu_write(16'hBFFE, 8'hFE);
    cpu_write(REG_IRQ_ON, 8'h00);
    send(OP_TICK, 16'hFFFF, 8'hFF, LAST_VISIBLE, 1'b1);
    send(OP_TICK, 16'h0000, 8'h00, 9'd240, 1'b1);
    send(OP_TICK, 16'h0000, 8'h00, 9'd100, 1'b0);
    send(OP_TICK, 16'h0000, 8'h00, 9'd261, 1'b1);

    // Outer writes at both extremes; a select write afterwards brings the PRG swap
    // bit back into the windows. Unused decoded addresses must be ignored.
    send(OP_OUTER, 16'h6000, 8'hFF, 9'd0, 1'b0);
    send(OP_OUTER, 16'h4020, 8'h00, 9'd0, 1'b0);
    cpu_write(REG_SELECT, PRG_SWAP_BIT);
    cpu_write(16'hFFFF, 8'hFF);
    cpu_write(16'h0000, 8'h00);

    // Random phases, each under its own configuration written while the mapper is
    // idle. The IRQ state carries over from one phase into the next.
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(CFG_PRG_COUNT, {2'($urandom), 10'(prg_set[ph])});
      write_reg(CFG_CHR_COUNT, 12'(chr_set[ph]));
      write_reg(CFG_FOUR_SCREEN, {11'($urandom), 1'(fs_set[ph])});
      if (ph == PHASES - 1) calm <= 1'b1;
      quota = sent + PHASE_ITEMS;
      while (sent < quota) random_item();
    end

    drain();
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
